// ----- rtl/signed_restoring_divider_core_defines.svh -----
// ----------------------------------------------------------------------------
// Signed restoring divider assertion macros
// Shared property shorthands for the divider checker.
// ----------------------------------------------------------------------------
`ifndef SIGNED_RESTORING_DIVIDER_CORE_DEFINES_SVH
`define SIGNED_RESTORING_DIVIDER_CORE_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle
`define SRD_ASSERT_NOW(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("divider check failed: same-cycle implication");

// Check that a condition implies a consequence in the next cycle
`define SRD_ASSERT_NEXT(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("divider check failed: next-cycle implication");

`endif

// ----- rtl/srd_pkg.sv -----
// ----------------------------------------------------------------------------
// Signed restoring divider package
// Default width and stream packing helpers shared across the divider.
// ----------------------------------------------------------------------------
package srd_pkg;

  // Default operand width
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Round a bit count up to whole bytes
  function automatic int unsigned byte_pad(input int unsigned bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

// ----- rtl/srd_prep.sv -----
// ----------------------------------------------------------------------------
// Divider operand stage
// Registers saturated operand magnitudes, result sign and zero-divisor flag.
// ----------------------------------------------------------------------------
module srd_prep #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] numerator,
  input  logic signed [DATA_WIDTH-1:0] denominator,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic        [DATA_WIDTH-2:0] n_mag,
  output logic        [DATA_WIDTH-2:0] d_mag,
  output logic                         neg,
  output logic                         dz
);

  logic [DATA_WIDTH-2:0] n_abs;
  logic [DATA_WIDTH-2:0] d_abs;

  // Magnitude, with the most negative value saturated to the largest magnitude
  function automatic logic [DATA_WIDTH-2:0] mag(input logic [DATA_WIDTH-1:0] v);
    logic [DATA_WIDTH-1:0] t;
    t = v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
    if (t[DATA_WIDTH-1]) begin
      mag = '1;
    end else begin
      mag = t[DATA_WIDTH-2:0];
    end
  endfunction

  assign n_abs    = mag(numerator);
  assign d_abs    = mag(denominator);
  assign in_ready = !out_valid || out_ready;

  // Hold the valid flag until downstream takes the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Capture operands on each accepted transaction
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      n_mag <= n_abs;
      d_mag <= d_abs;
      neg   <= numerator[DATA_WIDTH-1] ^ denominator[DATA_WIDTH-1];
      dz    <= (d_abs == '0);
    end
  end

endmodule

// ----- rtl/srd_cell.sv -----
// ----------------------------------------------------------------------------
// Divider bit cell
// One restoring step: shift in a numerator bit, trial subtract, keep or restore.
// ----------------------------------------------------------------------------
module srd_cell #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_WIDTH-2:0] n_in,
  input  logic [DATA_WIDTH-2:0] d_in,
  input  logic [DATA_WIDTH-2:0] r_in,
  input  logic [DATA_WIDTH-2:0] q_in,
  input  logic                  neg_in,
  input  logic                  dz_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-2:0] n_out,
  output logic [DATA_WIDTH-2:0] d_out,
  output logic [DATA_WIDTH-2:0] r_out,
  output logic [DATA_WIDTH-2:0] q_out,
  output logic                  neg_out,
  output logic                  dz_out
);

  logic [DATA_WIDTH-1:0] rs;
  logic [DATA_WIDTH:0]   diff;
  logic                  ge;
  logic [DATA_WIDTH-2:0] r_next;

  // Trial subtract of the divisor from the shifted partial remainder
  assign rs     = {r_in, n_in[DATA_WIDTH-2]};
  assign diff   = {1'b0, rs} - {2'b00, d_in};
  assign ge     = !diff[DATA_WIDTH];
  assign r_next = ge ? diff[DATA_WIDTH-2:0] : rs[DATA_WIDTH-2:0];

  assign in_ready = !out_valid || out_ready;

  // Hold the valid flag until the next cell takes the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Advance remainder, quotient and numerator by one bit
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      n_out   <= {n_in[DATA_WIDTH-3:0], 1'b0};
      d_out   <= d_in;
      r_out   <= r_next;
      q_out   <= {q_in[DATA_WIDTH-3:0], ge};
      neg_out <= neg_in;
      dz_out  <= dz_in;
    end
  end

endmodule

// ----- rtl/srd_post.sv -----
// ----------------------------------------------------------------------------
// Divider result stage
// Applies the quotient sign, clears the remainder on a zero divisor.
// ----------------------------------------------------------------------------
module srd_post #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic        [DATA_WIDTH-2:0] q_in,
  input  logic        [DATA_WIDTH-2:0] r_in,
  input  logic                         neg_in,
  input  logic                         dz_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] quotient,
  output logic        [DATA_WIDTH-2:0] remainder
);

  logic [DATA_WIDTH-1:0] q_ext;

  assign q_ext    = {1'b0, q_in};
  assign in_ready = !out_valid || out_ready;

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Negate the quotient when operand signs differ; zero stays zero
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      quotient  <= neg_in ? (~q_ext + 1'b1) : q_ext;
      remainder <= dz_in ? '0 : r_in;
    end
  end

endmodule

// ----- rtl/signed_restoring_divider_core.sv -----
// Throughput: one division per cycle when not stalled; each quotient bit has its own cell in a
// chain of DATA_WIDTH - 1 cells, between an operand stage and a result stage.
// Every stage stalls only when it is full and its successor is stalled.
// Reset clears all stage valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
// Signed restoring divider core
// Pipelined signed division with truncated quotient and magnitude remainder.
// ----------------------------------------------------------------------------
module signed_restoring_divider_core #(
  parameter int unsigned DATA_WIDTH = srd_pkg::DATA_WIDTH_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            s_tvalid,
  output logic                                            s_tready,
  // numerator [DATA_WIDTH-1:0], denominator above it, zero padded
  input  logic [srd_pkg::byte_pad(2*DATA_WIDTH)-1:0]      s_tdata,
  output logic                                            m_tvalid,
  input  logic                                            m_tready,
  // quotient [DATA_WIDTH-1:0], remainder above it, zero padded
  output logic [srd_pkg::byte_pad(2*DATA_WIDTH-1)-1:0]    m_tdata
);

  import srd_pkg::*;

  localparam int unsigned OUT_W = byte_pad(2 * DATA_WIDTH - 1);
  localparam int unsigned CELLS = DATA_WIDTH - 1;

  logic                  c_valid [CELLS+1];
  logic                  c_ready [CELLS+1];
  logic [DATA_WIDTH-2:0] c_n     [CELLS+1];
  logic [DATA_WIDTH-2:0] c_d     [CELLS+1];
  logic [DATA_WIDTH-2:0] c_r     [CELLS+1];
  logic [DATA_WIDTH-2:0] c_q     [CELLS+1];
  logic                  c_neg   [CELLS+1];
  logic                  c_dz    [CELLS+1];

  logic signed [DATA_WIDTH-1:0] quotient;
  logic        [DATA_WIDTH-2:0] remainder;

  // Operand stage
  srd_prep #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_prep (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .numerator   (s_tdata[DATA_WIDTH-1:0]),
    .denominator (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .out_valid   (c_valid[0]),
    .out_ready   (c_ready[0]),
    .n_mag       (c_n[0]),
    .d_mag       (c_d[0]),
    .neg         (c_neg[0]),
    .dz          (c_dz[0])
  );

  // Partial remainder and quotient start at zero
  assign c_r[0] = '0;
  assign c_q[0] = '0;

  // Chain of bit cells, most significant quotient bit first
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    srd_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[k]),
      .in_ready  (c_ready[k]),
      .n_in      (c_n[k]),
      .d_in      (c_d[k]),
      .r_in      (c_r[k]),
      .q_in      (c_q[k]),
      .neg_in    (c_neg[k]),
      .dz_in     (c_dz[k]),
      .out_valid (c_valid[k+1]),
      .out_ready (c_ready[k+1]),
      .n_out     (c_n[k+1]),
      .d_out     (c_d[k+1]),
      .r_out     (c_r[k+1]),
      .q_out     (c_q[k+1]),
      .neg_out   (c_neg[k+1]),
      .dz_out    (c_dz[k+1])
    );
  end

  // Result stage
  srd_post #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_post (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid[CELLS]),
    .in_ready  (c_ready[CELLS]),
    .q_in      (c_q[CELLS]),
    .r_in      (c_r[CELLS]),
    .neg_in    (c_neg[CELLS]),
    .dz_in     (c_dz[CELLS]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // Pack the result transaction
  assign m_tdata = OUT_W'({remainder, quotient});

endmodule

// ----- rtl/srd_checker.sv -----
// ----------------------------------------------------------------------------
// Signed restoring divider checker
// Port-level properties of the divider core, bound to the top level.
// ----------------------------------------------------------------------------
`include "signed_restoring_divider_core_defines.svh"

module srd_checker #(
  parameter int unsigned DATA_WIDTH = srd_pkg::DATA_WIDTH_DEF
) (
  input logic                                         clk,
  input logic                                         rst,
  input logic                                         s_tready,
  input logic                                         m_tvalid,
  input logic                                         m_tready,
  // quotient [DATA_WIDTH-1:0], remainder above it, zero padded
  input logic [srd_pkg::byte_pad(2*DATA_WIDTH-1)-1:0] m_tdata
);

  import srd_pkg::*;

  localparam int unsigned OUT_W = byte_pad(2 * DATA_WIDTH - 1);

  logic                  q_is_min;
  logic                  r_is_max;
  logic                  pad_clear;
  logic [OUT_W-1:0]      pad_mask;

  assign q_is_min  = (m_tdata[DATA_WIDTH-1:0] == {1'b1, {(DATA_WIDTH-1){1'b0}}});
  assign r_is_max  = (m_tdata[2*DATA_WIDTH-2:DATA_WIDTH] == '1);
  assign pad_mask  = ~OUT_W'({(2*DATA_WIDTH-1){1'b1}});
  assign pad_clear = ((m_tdata & pad_mask) == '0);

  // Stalled result holds valid and data
  `SRD_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // Pipeline is empty and ready right after reset
  `SRD_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !m_tvalid && s_tready)

  // Saturated operands keep the quotient off the most negative code
  `SRD_ASSERT_NOW(a_q_range, clk, rst, m_tvalid, !q_is_min)

  // Remainder stays below the largest magnitude, padding stays zero
  `SRD_ASSERT_NOW(a_r_range, clk, rst, m_tvalid, !r_is_max && pad_clear)

endmodule

bind signed_restoring_divider_core srd_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_srd_checker (.*);

// ----- verif/signed_restoring_divider_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Signed restoring divider stream test
// Streams operand pairs through the divider under random source and sink
// pacing and checks every quotient and remainder against an in-bench divider.
// ----------------------------------------------------------------------------
module signed_restoring_divider_core_test;

  localparam int unsigned DW      = srd_pkg::DATA_WIDTH_DEF;
  localparam int unsigned S_W     = srd_pkg::byte_pad(2*DW);
  localparam int unsigned M_W     = srd_pkg::byte_pad(2*DW-1);
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = DW + 8;

  localparam logic [DW-1:0] MAG_MAX  = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};

  // One expected division, with its operands kept for reporting
  typedef struct {
    logic [DW-1:0] numerator;
    logic [DW-1:0] denominator;
    logic [DW-1:0] quotient;
    logic [DW-2:0] remainder;
  } division_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  // numerator [DW-1:0], denominator above it
  logic [S_W-1:0] s_tdata = '0;
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  // quotient [DW-1:0], remainder above it, zero padded
  logic [M_W-1:0] m_tdata;

  division_t      pending_divisions[$];
  int unsigned    error_count = 0;
  int unsigned    sent_count = 0;
  int unsigned    checked_count = 0;
  int unsigned    zero_divisor_count = 0;
  int unsigned    most_neg_count = 0;
  int unsigned    idle_cycles = 0;
  int unsigned    hold_request = 0;
  bit             sink_stalls = 1'b1;

  signed_restoring_divider_core #(
    .DATA_WIDTH(DW)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // Divide magnitudes bit by bit, then fix up the quotient sign
  function automatic division_t divide_signed(input logic [DW-1:0] num,
                                              input logic [DW-1:0] den);
    division_t     res;
    logic          num_neg;
    logic          den_neg;
    logic [DW-1:0] num_mag;
    logic [DW-1:0] den_mag;
    logic [DW-1:0] partial;
    logic [DW-1:0] quot;
    num_neg = num[DW-1];
    den_neg = den[DW-1];
    num_mag = num_neg ? -num : num;
    den_mag = den_neg ? -den : den;
    if (num_mag > MAG_MAX) num_mag = MAG_MAX;
    if (den_mag > MAG_MAX) den_mag = MAG_MAX;
    partial = '0;
    quot    = '0;
    if (den_mag == '0) begin
      quot = MAG_MAX;
    end else begin
      for (int i = DW-2; i >= 0; i--) begin
        partial = {partial[DW-2:0], num_mag[i]};
        if (partial >= den_mag) begin
          partial = partial - den_mag;
          quot[i] = 1'b1;
        end
      end
    end
    if (num_neg != den_neg) quot = -quot;
    res.numerator   = num;
    res.denominator = den;
    res.quotient    = quot;
    res.remainder   = partial[DW-2:0];
    return res;
  endfunction

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [DW-1:0] apply_sign(input logic [DW-1:0] mag,
                                               input int unsigned neg);
    return (neg != 0) ? -mag : mag;
  endfunction

  // Boundary operands: zero, unit, extremes, powers of two and their neighbors
  function automatic logic [DW-1:0] boundary_operand();
    logic [DW-1:0] pow;
    pow = {{(DW-1){1'b0}}, 1'b1} << $urandom_range(0, DW-2);
    case ($urandom_range(0, 6))
      0: return '0;
      1: return apply_sign(1, $urandom_range(0, 1));
      2: return MAG_MAX;
      3: return -MAG_MAX;
      4: return MOST_NEG;
      5: return apply_sign(pow, $urandom_range(0, 1));
      default: return apply_sign(pow - 1, $urandom_range(0, 1));
    endcase
  endfunction

  // Offer one operand pair, hold it until accepted, then idle for the given gap
  task automatic send_operands(input logic [DW-1:0] num, input logic [DW-1:0] den,
                               input int unsigned gap);
    s_tvalid <= 1'b1;
    s_tdata  <= {den, num};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_divisions.push_back(divide_signed(num, den));
    sent_count++;
    if (den == '0) zero_divisor_count++;
    if (num == MOST_NEG || den == MOST_NEG) most_neg_count++;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every division has come back
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    while (pending_divisions.size() != 0) @(posedge clk);
  endtask

  function automatic int unsigned source_gap();
    return ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
  endfunction

  task automatic test_corner_operands();
    send_operands(0, 1, source_gap());
    send_operands(0, -1, source_gap());
    send_operands(0, 0, source_gap());
    send_operands(7, 0, source_gap());
    send_operands(-7, 0, source_gap());
    send_operands(MOST_NEG, 0, source_gap());
    send_operands(MAG_MAX, 1, source_gap());
    send_operands(MAG_MAX, -1, source_gap());
    send_operands(-MAG_MAX, 1, source_gap());
    send_operands(MOST_NEG, 1, source_gap());
    send_operands(MOST_NEG, MOST_NEG, source_gap());
    send_operands(MAG_MAX, MOST_NEG, source_gap());
    send_operands(1, MOST_NEG, source_gap());
    send_operands(0, MOST_NEG, source_gap());
    send_operands(7, 2, source_gap());
    send_operands(-7, 2, source_gap());
    send_operands(7, -2, source_gap());
    send_operands(-7, -2, source_gap());
    send_operands(1, MAG_MAX, source_gap());
    send_operands(MAG_MAX, MAG_MAX, source_gap());
    send_operands(-1, -1, source_gap());
    send_operands(5, 7, source_gap());
    send_operands(MAG_MAX, 2, source_gap());
    send_operands(100, -MAG_MAX, source_gap());
    wait_for_drain();
  endtask

  // Mix of operand shapes so that every quotient bit and both signs get exercised
  task automatic test_random_operands(input int unsigned count, input bit paced);
    logic [DW-1:0] num;
    logic [DW-1:0] den;
    longint        dmag;
    longint        qmag;
    longint        nmag;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          num = $urandom;
          den = $urandom;
        end
        3: begin
          num = $urandom;
          den = apply_sign($urandom_range(1, 255), $urandom_range(0, 1));
        end
        4: begin
          num = apply_sign($urandom_range(0, 1000), $urandom_range(0, 1));
          den = apply_sign($urandom_range(0, 1000), $urandom_range(0, 1));
        end
        5: begin
          // Build num as a multiple of den plus a small remainder
          dmag = $urandom_range(1, 65535);
          qmag = $urandom_range(0, int'(longint'(MAG_MAX) / dmag));
          nmag = qmag * dmag;
          if ($urandom_range(0, 1) == 1 && nmag + dmag - 1 <= longint'(MAG_MAX))
            nmag = nmag + $urandom_range(0, int'(dmag - 1));
          num = apply_sign(nmag[DW-1:0], $urandom_range(0, 1));
          den = apply_sign(dmag[DW-1:0], $urandom_range(0, 1));
        end
        6: begin
          num = $urandom;
          den = ($urandom_range(0, 1) == 1) ? '0 : boundary_operand();
        end
        7: begin
          num = boundary_operand();
          den = boundary_operand();
        end
        8: begin
          num = $urandom;
          den = apply_sign($urandom >> $urandom_range(1, DW-1), $urandom_range(0, 1));
        end
        default: begin
          // Divisor larger than dividend: zero quotient, full remainder
          num = apply_sign($urandom_range(0, 65535), $urandom_range(0, 1));
          den = apply_sign($urandom_range(65536, int'(MAG_MAX)), $urandom_range(0, 1));
        end
      endcase
      send_operands(num, den, paced ? source_gap() : 0);
    end
    wait_for_drain();
  endtask

  // Stall the sink for a long stretch while the source keeps pushing
  task automatic test_backpressure();
    hold_request = 160;
    test_random_operands(120, 1'b0);
    hold_request = 200;
    test_random_operands(80, 1'b1);
  endtask

  // Run back to back with neither side idling
  task automatic test_steady_stream();
    sink_stalls = 1'b0;
    test_random_operands(120, 1'b0);
    sink_stalls = 1'b1;
  endtask

  // Pace the sink: random stalls, or a long hold when requested
  initial begin : sink_pacing
    int unsigned stall;
    @(posedge clk);
    forever begin
      if (hold_request != 0) begin
        stall = hold_request;
        hold_request = 0;
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Check each result transaction against the oldest expected division
  always @(posedge clk) begin
    division_t exp_div;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_divisions.size() == 0) begin
        $display("%0t: unexpected result, quotient %0d remainder %0d", $time,
                 $signed(m_tdata[DW-1:0]), m_tdata[2*DW-2:DW]);
        error_count++;
      end else begin
        exp_div = pending_divisions.pop_front();
        checked_count++;
        if (m_tdata[DW-1:0] !== exp_div.quotient) begin
          $display("%0t: quotient of %0d / %0d: expected %0d, actual %0d", $time,
                   $signed(exp_div.numerator), $signed(exp_div.denominator),
                   $signed(exp_div.quotient), $signed(m_tdata[DW-1:0]));
          error_count++;
        end
        if (m_tdata[2*DW-2:DW] !== exp_div.remainder) begin
          $display("%0t: remainder of %0d / %0d: expected %0d, actual %0d", $time,
                   $signed(exp_div.numerator), $signed(exp_div.denominator),
                   exp_div.remainder, m_tdata[2*DW-2:DW]);
          error_count++;
        end
      end
    end
  end

  // Abort when no transaction moves on either side for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
               idle_cycles, pending_divisions.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_operands();
    test_random_operands(1300, 1'b1);
    test_backpressure();
    test_steady_stream();

    // Let any stray result show up before closing
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d divisions, %0d checked: %0d by zero, %0d with the most negative operand",
             sent_count, checked_count, zero_divisor_count, most_neg_count);
    $display("Ran corner operands, mixed random operands, long sink holds and a steady stream");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
